>>> hw/rtl/rpf_pkg.sv
// Shared types and constants for the rectangle placement fitness unit.
package rpf_pkg;

  // CORDIC chain length and datapath widths
  localparam int CORD_N  = 16;
  localparam int CORD_W  = 33;
  localparam int COORD_W = 34;
  localparam int MAC_W   = 35;
  localparam int MAC_PW  = 2 * MAC_W;
  localparam int MAC_RW  = MAC_PW + 1;
  localparam int QUAD_REGS = 8;
  localparam int CFG_IW    = 4;

  // Input commands
  localparam logic CMD_LOAD = 1'b0;
  localparam logic CMD_EVAL = 1'b1;

  // CORDIC start value (gain-compensated unit vector, Q2.30)
  localparam logic signed [CORD_W-1:0] CORD_X0 = 33'sh026DD3B6A;

  // Rotation step angles in units of 2^-32 turn
  localparam logic [31:0] ATAN_TURNS [CORD_N] = '{
    32'h20000000, 32'h12E4051E, 32'h09FB385B, 32'h051111D4,
    32'h028B0D43, 32'h0145D7E1, 32'h00A2F61E, 32'h00517C55,
    32'h0028BE53, 32'h00145F2F, 32'h000A2F98, 32'h000517CC,
    32'h00028BE6, 32'h000145F3, 32'h0000A2FA, 32'h0000517D
  };

  typedef struct packed {
    logic               cmd;
    logic [1:0]         slot;
    logic signed [31:0] center_x;
    logic signed [31:0] center_y;
    logic signed [31:0] rect_width;
    logic signed [31:0] rect_height;
    logic [15:0]        angle;
  } in_item_t;

  typedef struct packed {
    logic signed [63:0] area;
    logic               inside_quad;
    logic               hits_obstacle;
  } out_item_t;

  typedef struct packed {
    logic signed [CORD_W-1:0] x;
    logic signed [CORD_W-1:0] y;
    logic signed [CORD_W-1:0] z;
  } cord_t;

  typedef struct packed {
    logic                    go;
    logic                    sub;
    logic signed [MAC_W-1:0] a;
    logic signed [MAC_W-1:0] b;
    logic signed [MAC_W-1:0] c;
    logic signed [MAC_W-1:0] d;
  } mac_req_t;

  typedef struct packed {
    logic                     done;
    logic signed [MAC_RW-1:0] res;
  } mac_rsp_t;

endpackage

>>> hw/rtl/rpf_cordic_cell.sv
// One CORDIC rotation step, registered, for a chain of such cells.
module rpf_cordic_cell import rpf_pkg::*; #(
  parameter int STEP = 0
) (
  input  logic  clk,
  input  cord_t cin,
  output cord_t cout
);

  cord_t cell_r;
  cord_t cell_nxt;
  logic signed [CORD_W-1:0] dx;
  logic signed [CORD_W-1:0] dy;
  logic signed [CORD_W-1:0] at;

  // Rotate toward zero residual angle
  always_comb begin
    dx = cin.y >>> STEP;
    dy = cin.x >>> STEP;
    at = $signed({1'b0, ATAN_TURNS[STEP]});
    if (!cin.z[CORD_W-1]) begin
      cell_nxt.x = cin.x - dx;
      cell_nxt.y = cin.y + dy;
      cell_nxt.z = cin.z - at;
    end else begin
      cell_nxt.x = cin.x + dx;
      cell_nxt.y = cin.y - dy;
      cell_nxt.z = cin.z + at;
    end
  end

  // Hand the vector to the next cell
  always_ff @(posedge clk) begin
    cell_r <= cell_nxt;
  end

  assign cout = cell_r;

endmodule

>>> hw/rtl/rpf_mac.sv
// Two-stage multiply and add/subtract unit: a*b +/- c*d.
module rpf_mac import rpf_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  mac_req_t req,
  output mac_rsp_t rsp
);

  logic signed [MAC_PW-1:0] p1_r;
  logic signed [MAC_PW-1:0] p2_r;
  logic signed [MAC_RW-1:0] res_r;
  logic                     sub_r;
  logic                     v1_r;
  logic                     v2_r;

  // Track the operation through both stages
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
    end else begin
      v1_r <= req.go;
      v2_r <= v1_r;
    end
  end

  // Multiply, then combine
  always_ff @(posedge clk) begin
    if (req.go) begin
      p1_r  <= req.a * req.b;
      p2_r  <= req.c * req.d;
      sub_r <= req.sub;
    end
    if (v1_r) begin
      if (sub_r) begin
        res_r <= MAC_RW'(p1_r) - MAC_RW'(p2_r);
      end else begin
        res_r <= MAC_RW'(p1_r) + MAC_RW'(p2_r);
      end
    end
  end

  assign rsp.done = v2_r;
  assign rsp.res  = res_r;

endmodule

>>> hw/rtl/rect_placement_fitness_unit.sv
// Top level: rotated rectangle scoring against a quadrilateral and obstacle table.
//
//   channel | direction | ports                          | item
//   in      | input     | in_valid, in_ready, in_data    | load obstacle or evaluate candidate
//   out     | output    | out_valid, out_ready, out_data | area, inside_quad, hits_obstacle
//   cfg     | input     | cfg_valid, cfg_ready, cfg_index, cfg_data | quadrilateral vertex write
//
// A load passes through the 16-cell CORDIC chain, then makes 8 corner operations
// in the shared multiply unit. In an evaluation, every crossing test and projection
// is one pass through the multiply unit.
// Reset (rst_n, synchronous) clears the quadrilateral and the obstacle valid bits.
// A result waits in the output register; the next item is taken meanwhile, and
// the block stalls only when a second result meets a full output register.
module rect_placement_fitness_unit import rpf_pkg::*; #(
  parameter int OBSTACLES = 4
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  in_item_t          in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output out_item_t         out_data,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [31:0]       cfg_data
);

  localparam int OBS_IW = (OBSTACLES > 1) ? $clog2(OBSTACLES) : 1;
  localparam int OBS_CW = $clog2(OBSTACLES + 1);
  localparam int CNT_W  = $clog2(CORD_N + 1);

  localparam logic [3:0] S_IDLE    = 4'd0;
  localparam logic [3:0] S_CORD    = 4'd1;
  localparam logic [3:0] S_CORN    = 4'd2;
  localparam logic [3:0] S_CORN_W  = 4'd3;
  localparam logic [3:0] S_CROSS   = 4'd4;
  localparam logic [3:0] S_CROSS_W = 4'd5;
  localparam logic [3:0] S_OBS     = 4'd6;
  localparam logic [3:0] S_AXIS    = 4'd7;
  localparam logic [3:0] S_PROJ    = 4'd8;
  localparam logic [3:0] S_PROJ_W  = 4'd9;
  localparam logic [3:0] S_AREA    = 4'd10;
  localparam logic [3:0] S_AREA_W  = 4'd11;
  localparam logic [3:0] S_DONE    = 4'd12;

  logic [3:0] state_r;
  logic [3:0] state_nxt;

  logic signed [31:0] quad_r [QUAD_REGS];
  logic [OBSTACLES-1:0] obs_valid_r;
  logic signed [COORD_W-1:0] obs_x_r [OBSTACLES][4];
  logic signed [COORD_W-1:0] obs_y_r [OBSTACLES][4];

  in_item_t  item_r;
  out_item_t out_r;
  logic      out_valid_r;
  logic [CNT_W-1:0] cnt_r;
  logic signed [CORD_W-1:0] cos_r;
  logic signed [CORD_W-1:0] sin_r;
  logic [1:0] k_r;
  logic       half_r;
  logic signed [COORD_W-1:0] xtmp_r;
  logic signed [COORD_W-1:0] pts_x_r [8];
  logic signed [COORD_W-1:0] pts_y_r [8];
  logic signed [31:0] qv_x_r [4];
  logic signed [31:0] qv_y_r [4];
  logic [1:0] ci_r;
  logic [1:0] ei_r;
  logic       par_r;
  logic       cond_r;
  logic       dpos_r;
  logic       inside_r;
  logic       hits_r;
  logic [OBS_CW-1:0] oi_r;
  logic [1:0] ax_r;
  logic [2:0] pi_r;
  logic signed [MAC_W-1:0] axx_r;
  logic signed [MAC_W-1:0] axy_r;
  logic signed [MAC_RW-1:0] mn1_r;
  logic signed [MAC_RW-1:0] mx1_r;
  logic signed [MAC_RW-1:0] mn2_r;
  logic signed [MAC_RW-1:0] mx2_r;
  logic signed [63:0] area_r;

  cord_t    chain [CORD_N+1];
  mac_req_t mreq;
  mac_rsp_t mrsp;

  logic out_free;
  logic slot_ok;
  logic store_en;
  logic [OBS_IW-1:0] wr_idx;
  logic [OBS_IW-1:0] rd_idx;
  logic signed [31:0] ctr;
  logic signed [COORD_W-1:0] coord_nxt;
  logic sx_pos;
  logic sy_pos;
  logic signed [MAC_W-1:0] wv;
  logic signed [MAC_W-1:0] hv;
  logic signed [COORD_W-1:0] yi_e;
  logic signed [COORD_W-1:0] yj_e;
  logic cross_cond;
  logic signed [32:0] dq;
  logic cross_hit;
  logic par_nxt;
  logic signed [MAC_W-1:0] nx;
  logic signed [MAC_W-1:0] ny;
  logic set2;
  logic first;
  logic signed [MAC_RW-1:0] mn1_nxt;
  logic signed [MAC_RW-1:0] mx1_nxt;
  logic signed [MAC_RW-1:0] mn2_nxt;
  logic signed [MAC_RW-1:0] mx2_nxt;
  logic sep;

  assign in_ready  = (state_r == S_IDLE);
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_data  = out_r;
  assign out_free  = !out_valid_r || out_ready;

  // CORDIC chain fed from the held angle
  assign chain[0].x = CORD_X0;
  assign chain[0].y = '0;
  assign chain[0].z = $signed(CORD_W'({item_r.angle[13:0], 16'h0000}));

  for (genvar g = 0; g < CORD_N; g++) begin : g_cord
    rpf_cordic_cell #(.STEP(g)) u_cell (
      .clk  (clk),
      .cin  (chain[g]),
      .cout (chain[g+1])
    );
  end

  rpf_mac u_mac (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (mreq),
    .rsp   (mrsp)
  );

  // Table addressing
  assign slot_ok  = (32'(item_r.slot) < OBSTACLES);
  assign wr_idx   = OBS_IW'(item_r.slot);
  assign rd_idx   = oi_r[OBS_IW-1:0];
  assign store_en = (state_r == S_CORN_W) && mrsp.done && half_r && (k_r == 2'd3) &&
                    (item_r.cmd == CMD_LOAD) && slot_ok;

  // Corner coordinate from the multiply result
  always_comb begin
    ctr       = half_r ? item_r.center_y : item_r.center_x;
    coord_nxt = COORD_W'(ctr) + $signed(mrsp.res[31 +: COORD_W]);
    sx_pos    = (k_r == 2'd1) || (k_r == 2'd2);
    sy_pos    = k_r[1];
    wv        = MAC_W'(item_r.rect_width);
    hv        = MAC_W'(item_r.rect_height);
  end

  // Crossing test of ring point 0 against quad edge (vertex 3, vertex 0)
  always_comb begin
    yi_e       = COORD_W'(qv_y_r[0]);
    yj_e       = COORD_W'(qv_y_r[3]);
    cross_cond = (yi_e > pts_y_r[0]) != (yj_e > pts_y_r[0]);
    dq         = 33'(qv_y_r[3]) - 33'(qv_y_r[0]);
    cross_hit  = cond_r && (dpos_r ? (mrsp.res < 0) : (mrsp.res > 0));
    par_nxt    = par_r ^ cross_hit;
  end

  // Edge normal for the current axis
  always_comb begin
    unique case (ax_r)
      2'd0: begin
        nx = MAC_W'(pts_y_r[0]) - MAC_W'(pts_y_r[1]);
        ny = MAC_W'(pts_x_r[1]) - MAC_W'(pts_x_r[0]);
      end
      2'd1: begin
        nx = MAC_W'(pts_y_r[1]) - MAC_W'(pts_y_r[2]);
        ny = MAC_W'(pts_x_r[2]) - MAC_W'(pts_x_r[1]);
      end
      2'd2: begin
        nx = MAC_W'(pts_y_r[4]) - MAC_W'(pts_y_r[5]);
        ny = MAC_W'(pts_x_r[5]) - MAC_W'(pts_x_r[4]);
      end
      default: begin
        nx = MAC_W'(pts_y_r[5]) - MAC_W'(pts_y_r[6]);
        ny = MAC_W'(pts_x_r[6]) - MAC_W'(pts_x_r[5]);
      end
    endcase
  end

  // Projection extent tracking
  always_comb begin
    set2    = pi_r[2];
    first   = (pi_r[1:0] == 2'd0);
    mn1_nxt = (!set2 && (first || mrsp.res < mn1_r)) ? mrsp.res : mn1_r;
    mx1_nxt = (!set2 && (first || mx1_r < mrsp.res)) ? mrsp.res : mx1_r;
    mn2_nxt = (set2 && (first || mrsp.res < mn2_r)) ? mrsp.res : mn2_r;
    mx2_nxt = (set2 && (first || mx2_r < mrsp.res)) ? mrsp.res : mx2_r;
    sep     = (mx1_nxt < mn2_nxt) || (mx2_nxt < mn1_nxt);
  end

  // Multiply unit requests
  always_comb begin
    mreq     = '0;
    unique case (state_r)
      S_CORN: begin
        mreq.go = 1'b1;
        mreq.a  = sx_pos ? wv : -wv;
        if (!half_r) begin
          mreq.b = MAC_W'(cos_r);
          mreq.c = sy_pos ? -hv : hv;
          mreq.d = MAC_W'(sin_r);
        end else begin
          mreq.b = MAC_W'(sin_r);
          mreq.c = sy_pos ? hv : -hv;
          mreq.d = MAC_W'(cos_r);
        end
      end
      S_CROSS: begin
        mreq.go  = 1'b1;
        mreq.sub = 1'b1;
        mreq.a   = MAC_W'(pts_x_r[0]) - MAC_W'(qv_x_r[0]);
        mreq.b   = MAC_W'(dq);
        mreq.c   = MAC_W'(qv_x_r[3]) - MAC_W'(qv_x_r[0]);
        mreq.d   = MAC_W'(pts_y_r[0]) - MAC_W'(qv_y_r[0]);
      end
      S_PROJ: begin
        mreq.go = 1'b1;
        mreq.a  = MAC_W'(pts_x_r[0]);
        mreq.b  = axx_r;
        mreq.c  = MAC_W'(pts_y_r[0]);
        mreq.d  = axy_r;
      end
      S_AREA: begin
        mreq.go = 1'b1;
        mreq.a  = wv;
        mreq.b  = hv;
      end
      default: begin
        mreq.go = 1'b0;
      end
    endcase
  end

  // Sequencer
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE:    if (in_valid) state_nxt = S_CORD;
      S_CORD:    if (cnt_r == CNT_W'(CORD_N)) state_nxt = S_CORN;
      S_CORN:    state_nxt = S_CORN_W;
      S_CORN_W: begin
        if (mrsp.done) begin
          if (!half_r || k_r != 2'd3) begin
            state_nxt = S_CORN;
          end else if (item_r.cmd == CMD_LOAD) begin
            state_nxt = S_IDLE;
          end else begin
            state_nxt = S_CROSS;
          end
        end
      end
      S_CROSS:   state_nxt = S_CROSS_W;
      S_CROSS_W: begin
        if (mrsp.done) begin
          state_nxt = (ei_r == 2'd3 && ci_r == 2'd3) ? S_OBS : S_CROSS;
        end
      end
      S_OBS: begin
        if (oi_r == OBS_CW'(OBSTACLES)) begin
          state_nxt = S_AREA;
        end else if (obs_valid_r[rd_idx]) begin
          state_nxt = S_AXIS;
        end
      end
      S_AXIS:    state_nxt = S_PROJ;
      S_PROJ:    state_nxt = S_PROJ_W;
      S_PROJ_W: begin
        if (mrsp.done) begin
          if (pi_r != 3'd7) begin
            state_nxt = S_PROJ;
          end else if (sep || ax_r == 2'd3) begin
            state_nxt = S_OBS;
          end else begin
            state_nxt = S_AXIS;
          end
        end
      end
      S_AREA:    state_nxt = S_AREA_W;
      S_AREA_W:  if (mrsp.done) state_nxt = S_DONE;
      S_DONE:    if (out_free) state_nxt = S_IDLE;
      default:   state_nxt = S_IDLE;
    endcase
  end

  // Control state, configuration and valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      obs_valid_r <= '0;
      for (int i = 0; i < QUAD_REGS; i++) begin
        quad_r[i] <= '0;
      end
    end else begin
      state_r <= state_nxt;
      if (cfg_valid && (32'(cfg_index) < QUAD_REGS)) begin
        quad_r[cfg_index[2:0]] <= cfg_data;
      end
      if (store_en) begin
        obs_valid_r[wr_idx] <= 1'b1;
      end
      if (state_r == S_DONE && out_free) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  // Datapath
  always_ff @(posedge clk) begin
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          item_r <= in_data;
          cnt_r  <= '0;
          for (int i = 0; i < 4; i++) begin
            qv_x_r[i] <= quad_r[2*i];
            qv_y_r[i] <= quad_r[2*i+1];
          end
        end
      end
      S_CORD: begin
        cnt_r  <= cnt_r + 1'b1;
        k_r    <= 2'd0;
        half_r <= 1'b0;
        unique case (item_r.angle[15:14])
          2'd0: begin
            cos_r <= chain[CORD_N].x;
            sin_r <= chain[CORD_N].y;
          end
          2'd1: begin
            cos_r <= -chain[CORD_N].y;
            sin_r <= chain[CORD_N].x;
          end
          2'd2: begin
            cos_r <= -chain[CORD_N].x;
            sin_r <= -chain[CORD_N].y;
          end
          default: begin
            cos_r <= chain[CORD_N].y;
            sin_r <= -chain[CORD_N].x;
          end
        endcase
      end
      S_CORN_W: begin
        if (mrsp.done) begin
          if (!half_r) begin
            xtmp_r <= coord_nxt;
            half_r <= 1'b1;
          end else begin
            // Shift the finished corner into the candidate ring
            for (int i = 0; i < 3; i++) begin
              pts_x_r[i] <= pts_x_r[i+1];
              pts_y_r[i] <= pts_y_r[i+1];
            end
            pts_x_r[3] <= xtmp_r;
            pts_y_r[3] <= coord_nxt;
            half_r     <= 1'b0;
            k_r        <= k_r + 1'b1;
            ci_r       <= 2'd0;
            ei_r       <= 2'd0;
            par_r      <= 1'b0;
            inside_r   <= 1'b1;
            if (store_en) begin
              for (int i = 0; i < 3; i++) begin
                obs_x_r[wr_idx][i] <= pts_x_r[i+1];
                obs_y_r[wr_idx][i] <= pts_y_r[i+1];
              end
              obs_x_r[wr_idx][3] <= xtmp_r;
              obs_y_r[wr_idx][3] <= coord_nxt;
            end
          end
        end
      end
      S_CROSS: begin
        cond_r <= cross_cond;
        dpos_r <= (dq > 0);
      end
      S_CROSS_W: begin
        if (mrsp.done) begin
          // Advance to the next quad edge
          for (int i = 0; i < 3; i++) begin
            qv_x_r[i] <= qv_x_r[i+1];
            qv_y_r[i] <= qv_y_r[i+1];
          end
          qv_x_r[3] <= qv_x_r[0];
          qv_y_r[3] <= qv_y_r[0];
          ei_r      <= ei_r + 1'b1;
          if (ei_r == 2'd3) begin
            if (!par_nxt) inside_r <= 1'b0;
            par_r <= 1'b0;
            ci_r  <= ci_r + 1'b1;
            // Advance to the next candidate corner
            for (int i = 0; i < 3; i++) begin
              pts_x_r[i] <= pts_x_r[i+1];
              pts_y_r[i] <= pts_y_r[i+1];
            end
            pts_x_r[3] <= pts_x_r[0];
            pts_y_r[3] <= pts_y_r[0];
          end else begin
            par_r <= par_nxt;
          end
          if (ei_r == 2'd3 && ci_r == 2'd3) begin
            oi_r   <= '0;
            hits_r <= 1'b0;
          end
        end
      end
      S_OBS: begin
        if (oi_r != OBS_CW'(OBSTACLES)) begin
          if (obs_valid_r[rd_idx]) begin
            for (int i = 0; i < 4; i++) begin
              pts_x_r[4+i] <= obs_x_r[rd_idx][i];
              pts_y_r[4+i] <= obs_y_r[rd_idx][i];
            end
            ax_r <= 2'd0;
          end else begin
            oi_r <= oi_r + 1'b1;
          end
        end
      end
      S_AXIS: begin
        axx_r <= nx;
        axy_r <= ny;
        pi_r  <= 3'd0;
      end
      S_PROJ: begin
        // Rotate all eight points past the projection port
        for (int i = 0; i < 7; i++) begin
          pts_x_r[i] <= pts_x_r[i+1];
          pts_y_r[i] <= pts_y_r[i+1];
        end
        pts_x_r[7] <= pts_x_r[0];
        pts_y_r[7] <= pts_y_r[0];
      end
      S_PROJ_W: begin
        if (mrsp.done) begin
          mn1_r <= mn1_nxt;
          mx1_r <= mx1_nxt;
          mn2_r <= mn2_nxt;
          mx2_r <= mx2_nxt;
          pi_r  <= pi_r + 1'b1;
          if (pi_r == 3'd7) begin
            if (sep) begin
              oi_r <= oi_r + 1'b1;
            end else if (ax_r == 2'd3) begin
              hits_r <= 1'b1;
              oi_r   <= oi_r + 1'b1;
            end else begin
              ax_r <= ax_r + 1'b1;
            end
          end
        end
      end
      S_AREA_W: begin
        if (mrsp.done) area_r <= mrsp.res[63:0];
      end
      S_DONE: begin
        if (out_free) begin
          out_r.area          <= (inside_r && !hits_r) ? area_r : 64'sd0;
          out_r.inside_quad   <= inside_r;
          out_r.hits_obstacle <= hits_r;
        end
      end
      default: begin
        cnt_r <= cnt_r;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_mac_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    mrsp.done |-> (state_r == S_CORN_W || state_r == S_CROSS_W ||
                   state_r == S_PROJ_W || state_r == S_AREA_W))
    else $error("multiply result arrived outside a wait state");
  a_accept_starts: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> state_r == S_CORD)
    else $error("accepted item did not start the sine and cosine pass");
  a_result_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised without a finished evaluation");
`endif

endmodule
